FILE: rtl/simon_block_encrypt_defines.svh
// ----------------------------------------------------------------------------
// Simon block encrypt assertion macros
// Concurrent assertion helpers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SIMON_BLOCK_ENCRYPT_DEFINES_SVH
`define SIMON_BLOCK_ENCRYPT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SBE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbe: implication check failed");

`define SBE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbe: next-cycle check failed");

`else

`define SBE_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define SBE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/sbe_pkg.sv
// ----------------------------------------------------------------------------
// Simon block encrypt package
// Widths, register codes, z sequences and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sbe_pkg;

   localparam int DATA_BITS   = 32;
   localparam int WORD_BITS   = 32;
   localparam int MAX_ROUNDS  = 72;
   localparam int ZSEQ_LENGTH = 62;
   localparam int ZSEQ_COUNT  = 5;
   localparam int KEY_WORDS   = 4;

   localparam int ZPOS_BITS  = $clog2(ZSEQ_LENGTH);
   localparam int ROUND_BITS = 7;
   localparam int MCNT_BITS  = 3;
   localparam int ZSEL_BITS  = 3;
   localparam int KIDX_BITS  = $clog2(KEY_WORDS);
   localparam int CSR_BITS   = 3;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [DATA_BITS-1:0]  data_type;
   typedef logic [ROUND_BITS-1:0] round_type;
   typedef logic [MCNT_BITS-1:0]  mcnt_type;
   typedef logic [ZSEL_BITS-1:0]  zsel_type;
   typedef logic [ZPOS_BITS-1:0]  zpos_type;
   typedef logic [KIDX_BITS-1:0]  kidx_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_KEY0   = 3'd0,
      CSR_KEY1   = 3'd1,
      CSR_KEY2   = 3'd2,
      CSR_KEY3   = 3'd3,
      CSR_MCOUNT = 3'd4,
      CSR_ZSEL   = 3'd5,
      CSR_ROUNDS = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } sbe_state_type;

   typedef struct packed {
      logic load;
      logic step;
   } sbe_cmd_type;

   localparam mcnt_type  MCOUNT_MIN   = MCNT_BITS'(2);
   localparam mcnt_type  MCOUNT_MAX   = MCNT_BITS'(4);
   localparam zsel_type  ZSEL_MAX     = ZSEL_BITS'(ZSEQ_COUNT - 1);
   localparam round_type ROUNDS_MAX   = ROUND_BITS'(MAX_ROUNDS);
   localparam mcnt_type  MCOUNT_RESET = MCNT_BITS'(4);
   localparam zsel_type  ZSEL_RESET   = ZSEL_BITS'(3);
   localparam round_type ROUNDS_RESET = ROUND_BITS'(44);
   localparam word_type  KEY_CONST    = WORD_BITS'(3);
   localparam zpos_type  ZPOS_LAST    = ZPOS_BITS'(ZSEQ_LENGTH - 1);

   // first sequence element stands at the MSB
   localparam logic [ZSEQ_LENGTH-1:0] Z_SEQ [ZSEQ_COUNT] = '{
      62'b1111101000100101011000011100110_1111101000100101011000011100110,
      62'b1000111011111001001100001011010_1000111011111001001100001011010,
      62'b1010111101110000001101001001100_0101000010001111110010110110011,
      62'b1101101110101100011001011110000_0010010001010011100110100001111,
      62'b1101000111100110101101100010000_0010111000011001010010011101111
   };

   function automatic word_type rotl(word_type v, int unsigned s);
      return (v << s) | (v >> (WORD_BITS - s));
   endfunction

   function automatic word_type rotr(word_type v, int unsigned s);
      return (v >> s) | (v << (WORD_BITS - s));
   endfunction

   function automatic logic zbit(zsel_type sel, zpos_type pos);
      return Z_SEQ[sel][ZPOS_LAST - pos];
   endfunction

   function automatic mcnt_type clamp_mcount(mcnt_type m);
      mcnt_type r;
      r = m;
      if (m < MCOUNT_MIN) r = MCOUNT_MIN;
      if (m > MCOUNT_MAX) r = MCOUNT_MAX;
      return r;
   endfunction

   function automatic zsel_type clamp_zsel(zsel_type z);
      return (z > ZSEL_MAX) ? ZSEL_MAX : z;
   endfunction

   function automatic round_type clamp_rounds(round_type n);
      return (n > ROUNDS_MAX) ? ROUNDS_MAX : n;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sbe_datapath.sv
// ----------------------------------------------------------------------------
// Simon block encrypt datapath
// Round register pair, key window with on-the-fly expansion, z position.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_datapath
   import sbe_pkg::*;
(
   input  wire logic        clock,
   input  wire sbe_cmd_type cmd,
   input  wire data_type    plain_x,
   input  wire data_type    plain_y,
   input  wire data_type    master_key [KEY_WORDS],
   input  wire mcnt_type    mcount,
   input  wire zsel_type    zsel,
   output data_type         cipher_x,
   output data_type         cipher_y
);

   word_type x_ff, x_in;
   word_type y_ff, y_in;
   word_type key_ff [KEY_WORDS];
   word_type key_in [KEY_WORDS];
   zpos_type zpos_ff, zpos_in;

   kidx_type last_idx;
   word_type tmix;
   word_type new_key;

   always_comb begin
      last_idx = KIDX_BITS'(mcount - MCNT_BITS'(1));
      tmix = rotr(key_ff[last_idx], 3);
      if (mcount == MCOUNT_MAX) begin
         tmix = tmix ^ key_ff[1];
      end
      tmix = tmix ^ rotr(tmix, 1);
      new_key = ~key_ff[0] ^ tmix ^ WORD_BITS'(zbit(zsel, zpos_ff)) ^ KEY_CONST;
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      zpos_in = zpos_ff;
      for (int j = 0; j < KEY_WORDS; j++) begin
         key_in[j] = key_ff[j];
      end
      if (cmd.load) begin
         x_in    = plain_x[WORD_BITS-1:0];
         y_in    = plain_y[WORD_BITS-1:0];
         zpos_in = '0;
         for (int j = 0; j < KEY_WORDS; j++) begin
            key_in[j] = master_key[j][WORD_BITS-1:0];
         end
      end else if (cmd.step) begin
         x_in    = y_ff ^ (rotl(x_ff, 1) & rotl(x_ff, 8)) ^ rotl(x_ff, 2) ^ key_ff[0];
         y_in    = x_ff;
         zpos_in = (zpos_ff == ZPOS_LAST) ? '0 : zpos_ff + ZPOS_BITS'(1);
         for (int j = 0; j < KEY_WORDS - 1; j++) begin
            key_in[j] = (KIDX_BITS'(j) == last_idx) ? new_key : key_ff[j+1];
         end
         key_in[KEY_WORDS-1] = new_key;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      zpos_ff <= zpos_in;
      for (int j = 0; j < KEY_WORDS; j++) begin
         key_ff[j] <= key_in[j];
      end
   end

   assign cipher_x = DATA_BITS'(x_ff);
   assign cipher_y = DATA_BITS'(y_ff);

endmodule

`default_nettype wire

FILE: rtl/sbe_ctrl.sv
// ----------------------------------------------------------------------------
// Simon block encrypt controller
// Sequences load, one round per cycle, and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

`include "simon_block_encrypt_defines.svh"

module sbe_ctrl
   import sbe_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire round_type rounds,
   output logic           busy,
   output logic           rsp_valid,
   output sbe_cmd_type    cmd
);

   sbe_state_type state_ff, state_in;
   round_type     round_ff, round_in;
   logic          accept;
   logic          last_round;

   assign accept     = start && !busy;
   assign last_round = (round_ff == rounds - ROUND_BITS'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (start) begin
               state_in = (rounds == '0) ? ST_DONE : ST_RUN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (last_round) begin
               state_in = ST_DONE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff == ST_RUN);
      rsp_valid = (state_ff == ST_DONE);
      cmd.load  = start && (state_ff != ST_RUN);
      cmd.step  = (state_ff == ST_RUN);
   end

   always_comb begin
      round_in = round_ff;
      if (cmd.load) begin
         round_in = '0;
      end else if (cmd.step) begin
         round_in = round_ff + ROUND_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   `SBE_ASSERT_IMP(a_no_load_while_step, clock, reset, cmd.step, !cmd.load)
   `SBE_ASSERT_IMP(a_step_in_range, clock, reset, cmd.step, round_ff < rounds)
   `SBE_ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid)
   `SBE_ASSERT_IMP(a_strobe_not_busy, clock, reset, rsp_valid, !busy)

endmodule

`default_nettype wire

FILE: rtl/simon_block_encrypt.sv
// ----------------------------------------------------------------------------
// Simon block encrypt
// Simon encryption with on-the-fly key schedule and a plain CSR write port.
// ----------------------------------------------------------------------------
// A block is taken when start is high and busy is low. The round unit does one
// round per cycle while the key window expands the next round key beside it,
// so the result strobes on rsp_valid for exactly one cycle once the last round
// is registered (at most 72 rounds; none when rounds is zero). The
// receiver cannot stall: take the words while rsp_valid is high. A new block
// may be started during the strobe cycle. Write CSRs only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module simon_block_encrypt
   import sbe_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire data_type            req_plain_x,
   input  wire data_type            req_plain_y,
   output logic                     rsp_valid,
   output data_type                 rsp_cipher_x,
   output data_type                 rsp_cipher_y,
   input  wire logic                csr_write,
   input  wire logic [CSR_BITS-1:0] csr_index,
   input  wire data_type            csr_wdata
);

   data_type    key_ff [KEY_WORDS];
   mcnt_type    mcount_ff;
   zsel_type    zsel_ff;
   round_type   rounds_ff;
   sbe_cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < KEY_WORDS; j++) begin
            key_ff[j] <= '0;
         end
         mcount_ff <= MCOUNT_RESET;
         zsel_ff   <= ZSEL_RESET;
         rounds_ff <= ROUNDS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KEY0:   key_ff[0] <= csr_wdata;
            CSR_KEY1:   key_ff[1] <= csr_wdata;
            CSR_KEY2:   key_ff[2] <= csr_wdata;
            CSR_KEY3:   key_ff[3] <= csr_wdata;
            CSR_MCOUNT: mcount_ff <= csr_wdata[MCNT_BITS-1:0];
            CSR_ZSEL:   zsel_ff   <= csr_wdata[ZSEL_BITS-1:0];
            CSR_ROUNDS: rounds_ff <= csr_wdata[ROUND_BITS-1:0];
            default: ;
         endcase
      end
   end

   sbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .rounds    (clamp_rounds(rounds_ff)),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   sbe_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .plain_x    (req_plain_x),
      .plain_y    (req_plain_y),
      .master_key (key_ff),
      .mcount     (clamp_mcount(mcount_ff)),
      .zsel       (clamp_zsel(zsel_ff)),
      .cipher_x   (rsp_cipher_x),
      .cipher_y   (rsp_cipher_y)
   );

endmodule

`default_nettype wire
